### hdl/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg: shared definitions for the Melkman convex hull unit
// Default sizes and the result bundle of the orientation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mch_pkg;

	localparam int HULL_DEPTH_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	// result of one left-or-on test
	typedef struct packed {
		logic done;
		logic left;
	} orient_res_t;

endpackage

`default_nettype wire

### hdl/melkman_convex_hull_unit.sv
// ----------------------------------------------------------------------------
// melkman_convex_hull_unit: Melkman hull of a simple polyline
// Keeps the hull deque in a circular RAM and runs every end-edge test
// through one shared orientation pipeline under a small sequencer.
// ----------------------------------------------------------------------------
// The first vertex is held, the second builds the deque; each later vertex is
//   tested against both end edges, then skipped or pushed at both ends (not
//   pushed when the store is full), with one more test per popped entry.
// Each end-edge test does two RAM reads on the single read port,
//   then the 3-stage orientation pipeline; tests run one after another.
// Emission: one RAM read per hull vertex, loaded when the output slot is free.
// Reset (arst_n low) empties the deque at once; RAM contents are not cleared.
`default_nettype none

module melkman_convex_hull_unit import mch_pkg::*; #(
	parameter int HULL_DEPTH = HULL_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// vertex input
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] x_coord,
	input  wire logic signed [COORD_BITS-1:0] y_coord,
	input  wire logic                         last_point,
	// hull output
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      hull_x,
	output logic signed [COORD_BITS-1:0]      hull_y,
	output logic                              hull_last,
	output logic                              overflow
);

	localparam int PW = $clog2(HULL_DEPTH);      // deque pointer
	localparam int CW = $clog2(HULL_DEPTH + 1);  // entry count
	localparam int VW = 2 * COORD_BITS;          // packed vertex {x, y}

	typedef enum logic [3:0] {
		ST_IDLE, ST_BUILD0, ST_BUILD1, ST_BUILD2,
		ST_T_RA, ST_T_RB, ST_T_GO, ST_T_WAIT,
		ST_POP_B, ST_POP_F, ST_PUSH_B, ST_PUSH_F,
		ST_FINISH, ST_EM_ONE, ST_EM_RD, ST_EM_LD
	} state_t;

	// which end edge the current test looks at, and why
	typedef enum logic [1:0] {
		MD_CHK_BACK, MD_CHK_FRONT, MD_POP_BACK, MD_POP_FRONT
	} mode_t;

	state_t          state_q;
	mode_t           mode_q;
	logic [1:0]      seen_q;      // 0 none, 1 first vertex held, 2 deque built
	logic [PW-1:0]   front_q, back_q, em_ptr_q;
	logic [CW-1:0]   cnt_q, em_idx_q;
	logic [VW-1:0]   first_q, p_q, a_q;
	logic            last_q, ovf_q, lb_q, lf_q;
	logic            out_valid_q, hull_last_q, overflow_q;
	logic [COORD_BITS-1:0] hull_x_q, hull_y_q;

	logic            back_kind, full, slot_free, em_last, out_load;
	logic [PW-1:0]   addr_a, addr_b, raddr, waddr;
	logic            we;
	logic [VW-1:0]   wdata, rdata;
	orient_res_t     ores;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(HULL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(HULL_DEPTH - 1) : p - 1'b1;
	endfunction

	// ---- deque store ----
	mch_ram #(
		.WIDTH(VW),
		.DEPTH(HULL_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// ---- shared orientation unit: a = first read, b = second read, c = vertex ----
	mch_orient #(
		.COORD_BITS(COORD_BITS)
	) u_orient (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_T_GO),
		.ax    (a_q[VW-1:COORD_BITS]),
		.ay    (a_q[COORD_BITS-1:0]),
		.bx    (rdata[VW-1:COORD_BITS]),
		.by    (rdata[COORD_BITS-1:0]),
		.cx    (p_q[VW-1:COORD_BITS]),
		.cy    (p_q[COORD_BITS-1:0]),
		.res   (ores)
	);

	// back edge is back(1)->back(0), front edge is front(0)->front(1)
	assign back_kind = (mode_q == MD_CHK_BACK) || (mode_q == MD_POP_BACK);
	assign addr_a    = back_kind ? ptr_dec(back_q) : front_q;
	assign addr_b    = back_kind ? back_q : ptr_inc(front_q);

	assign full      = ({1'b0, cnt_q} + (CW+1)'(2)) > (CW+1)'(HULL_DEPTH);
	assign slot_free = !out_valid_q || out_ready;
	assign em_last   = ({1'b0, em_idx_q} + 1'b1) == {1'b0, cnt_q};
	// a new output beat goes into the register this cycle
	assign out_load  = slot_free && ((state_q == ST_EM_ONE) || (state_q == ST_EM_LD));

	always_comb begin
		case (state_q)
			ST_T_RA: raddr = addr_a;
			ST_T_RB: raddr = addr_b;
			default: raddr = em_ptr_q;
		endcase
	end

	// deque writes: initial P0,P1,P0, then pushes at both ends
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = p_q;
		case (state_q)
			ST_BUILD0: begin
				we    = 1'b1;
				waddr = PW'(0);
				wdata = first_q;
			end
			ST_BUILD1: begin
				we    = 1'b1;
				waddr = PW'(1);
			end
			ST_BUILD2: begin
				we    = 1'b1;
				waddr = PW'(2);
				wdata = first_q;
			end
			ST_PUSH_B: begin
				we    = !full;
				waddr = ptr_inc(back_q);
			end
			ST_PUSH_F: begin
				we    = 1'b1;
				waddr = ptr_dec(front_q);
			end
			default: begin
				we    = 1'b0;
			end
		endcase
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_CHK_BACK;
			seen_q      <= 2'd0;
			front_q     <= '0;
			back_q      <= '0;
			cnt_q       <= '0;
			em_ptr_q    <= '0;
			em_idx_q    <= '0;
			first_q     <= '0;
			p_q         <= '0;
			a_q         <= '0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
			lb_q        <= 1'b0;
			lf_q        <= 1'b0;
			out_valid_q <= 1'b0;
			hull_x_q    <= '0;
			hull_y_q    <= '0;
			hull_last_q <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			// output beat taken and nothing new loaded behind it
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						p_q    <= {x_coord, y_coord};
						last_q <= last_point;
						case (seen_q)
							2'd0: begin
								first_q <= {x_coord, y_coord};
								seen_q  <= 2'd1;
								if (last_point) begin
									state_q <= ST_EM_ONE;
								end
							end
							2'd1: begin
								state_q <= ST_BUILD0;
							end
							default: begin
								mode_q  <= MD_CHK_BACK;
								state_q <= ST_T_RA;
							end
						endcase
					end
				end

				ST_BUILD0: state_q <= ST_BUILD1;
				ST_BUILD1: state_q <= ST_BUILD2;
				ST_BUILD2: begin
					front_q <= '0;
					back_q  <= PW'(2);
					cnt_q   <= CW'(3);
					seen_q  <= 2'd2;
					state_q <= ST_FINISH;
				end

				// test: read a, read b, launch, wait for the pipeline
				ST_T_RA: state_q <= ST_T_RB;
				ST_T_RB: begin
					a_q     <= rdata;
					state_q <= ST_T_GO;
				end
				ST_T_GO: state_q <= ST_T_WAIT;
				ST_T_WAIT: begin
					if (ores.done) begin
						case (mode_q)
							MD_CHK_BACK: begin
								lb_q    <= ores.left;
								mode_q  <= MD_CHK_FRONT;
								state_q <= ST_T_RA;
							end
							MD_CHK_FRONT: begin
								lf_q <= ores.left;
								// left of or on both end edges: vertex is skipped
								state_q <= (lb_q && ores.left) ? ST_FINISH : ST_POP_B;
							end
							MD_POP_BACK: begin
								lb_q    <= ores.left;
								state_q <= ST_POP_B;
							end
							MD_POP_FRONT: begin
								lf_q    <= ores.left;
								state_q <= ST_POP_F;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end

				// back pops first; front edge is untouched by them
				ST_POP_B: begin
					if (cnt_q >= CW'(3) && !lb_q) begin
						back_q  <= ptr_dec(back_q);
						cnt_q   <= cnt_q - 1'b1;
						mode_q  <= MD_POP_BACK;
						state_q <= ST_T_RA;
					end else begin
						state_q <= ST_POP_F;
					end
				end
				ST_POP_F: begin
					if (cnt_q >= CW'(3) && !lf_q) begin
						front_q <= ptr_inc(front_q);
						cnt_q   <= cnt_q - 1'b1;
						mode_q  <= MD_POP_FRONT;
						state_q <= ST_T_RA;
					end else begin
						state_q <= ST_PUSH_B;
					end
				end

				ST_PUSH_B: begin
					if (full) begin
						ovf_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						back_q  <= ptr_inc(back_q);
						state_q <= ST_PUSH_F;
					end
				end
				ST_PUSH_F: begin
					front_q <= ptr_dec(front_q);
					cnt_q   <= cnt_q + CW'(2);
					state_q <= ST_FINISH;
				end

				ST_FINISH: begin
					if (last_q) begin
						em_ptr_q <= front_q;
						em_idx_q <= '0;
						state_q  <= ST_EM_RD;
					end else begin
						state_q  <= ST_IDLE;
					end
				end

				// single vertex run: emit it and clear
				ST_EM_ONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						hull_x_q    <= first_q[VW-1:COORD_BITS];
						hull_y_q    <= first_q[COORD_BITS-1:0];
						hull_last_q <= 1'b1;
						overflow_q  <= ovf_q;
						seen_q      <= 2'd0;
						front_q     <= '0;
						back_q      <= '0;
						cnt_q       <= '0;
						first_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end

				// deque walk front to back, one RAM read per beat
				ST_EM_RD: state_q <= ST_EM_LD;
				ST_EM_LD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						hull_x_q    <= rdata[VW-1:COORD_BITS];
						hull_y_q    <= rdata[COORD_BITS-1:0];
						hull_last_q <= em_last;
						overflow_q  <= ovf_q;
						if (em_last) begin
							seen_q  <= 2'd0;
							front_q <= '0;
							back_q  <= '0;
							cnt_q   <= '0;
							first_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							em_idx_q <= em_idx_q + 1'b1;
							em_ptr_q <= ptr_inc(em_ptr_q);
							state_q  <= ST_EM_RD;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign hull_x    = hull_x_q;
	assign hull_y    = hull_y_q;
	assign hull_last = hull_last_q;
	assign overflow  = overflow_q;

	// ---- checks ----
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HULL_DEPTH))
		else $error("deque count above capacity");

	a_cnt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q == 2'd2) |-> (cnt_q >= CW'(2)))
		else $error("built deque holds fewer than two entries");

	a_orient_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ores.done |-> (state_q == ST_T_WAIT))
		else $error("orientation result outside wait state");

	a_one_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_GO) |=> (state_q == ST_T_WAIT) && !ores.done)
		else $error("orientation launch sequence broken");

endmodule

`default_nettype wire

### hdl/mch_ram.sv
// ----------------------------------------------------------------------------
// mch_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/mch_orient.sv
// ----------------------------------------------------------------------------
// mch_orient: pipelined left-or-on test
// Three stages: edge differences, cross products, sign of the difference.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_orient import mch_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	output orient_res_t                       res
);

	localparam int DW = COORD_BITS + 1;
	localparam int PWD = 2 * DW;
	localparam int SW = PWD + 1;

	logic              v_s1, v_s2, v_s3;
	logic signed [DW-1:0]  d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [PWD-1:0] p1_s2, p2_s2;
	logic                  left_s3;
	logic [SW-1:0]         diff;

	// p1 - p2 >= 0 means c is left of or on a->b
	assign diff = {p1_s2[PWD-1], p1_s2} - {p2_s2[PWD-1], p2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d1x_s1  <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
		d1y_s1  <= $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
		d2x_s1  <= $signed({cx[COORD_BITS-1], cx}) - $signed({ax[COORD_BITS-1], ax});
		d2y_s1  <= $signed({cy[COORD_BITS-1], cy}) - $signed({ay[COORD_BITS-1], ay});
		p1_s2   <= d1x_s1 * d2y_s1;
		p2_s2   <= d1y_s1 * d2x_s1;
		left_s3 <= !diff[SW-1];
	end

	assign res = '{done: v_s3, left: left_s3};

endmodule

`default_nettype wire
